FILE: rtl/i8car_pkg.sv
// ----------------------------------------------------------------------------
// i8car_pkg
// Shared types and constants for the int8 accumulate and requantize block.
// ----------------------------------------------------------------------------
package i8car_pkg;

    localparam int unsigned BIAS_SHIFT_DEF = 8;

    localparam int unsigned ACT_W      = 8;
    localparam int unsigned ACC_W      = 32;
    localparam int unsigned WORK_W     = 64;
    localparam int unsigned COEF_W     = 32;
    localparam int unsigned SHAMT_W    = 6;
    localparam int unsigned TOTAL_W    = 7;
    localparam int unsigned IN_TDATA_W = 160;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PRELU_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_ZP        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZP_ADD   = 2'd2;

    localparam logic [SHAMT_W-1:0]    SHAMT_MAX = 6'd63;
    localparam logic [OUT_DATA_W-1:0] SAT_HI    = 8'h7f;
    localparam logic [OUT_DATA_W-1:0] SAT_LO    = 8'h80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_WORK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_RND_ADD,
        ST_RND_SHIFT,
        ST_FIN
    } state_t;

endpackage

FILE: rtl/i8car_mul.sv
// ----------------------------------------------------------------------------
// i8car_mul
// Shared 32 x 32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module i8car_mul (
    input  logic                                  aclk,
    input  logic [i8car_pkg::COEF_W-1:0]          mul_a,
    input  logic [i8car_pkg::COEF_W-1:0]          mul_b,
    output logic [i8car_pkg::WORK_W-1:0]          mul_p
);

    logic [i8car_pkg::WORK_W-1:0] prod;
    logic [i8car_pkg::WORK_W-1:0] prod_reg;

    assign prod = {{(i8car_pkg::WORK_W-i8car_pkg::COEF_W){1'b0}}, mul_a} *
                  {{(i8car_pkg::WORK_W-i8car_pkg::COEF_W){1'b0}}, mul_b};

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
    end

    assign mul_p = prod_reg;

endmodule

FILE: rtl/i8car_rnd.sv
// ----------------------------------------------------------------------------
// i8car_rnd
// Two-step rounding right shift: add half an output step, then shift
// arithmetically. A shift of zero passes the value through.
// ----------------------------------------------------------------------------
module i8car_rnd (
    input  logic                                  aclk,
    input  logic                                  add_en,
    input  logic [i8car_pkg::WORK_W-1:0]          value,
    input  logic [i8car_pkg::SHAMT_W-1:0]         shamt,
    output logic [i8car_pkg::WORK_W-1:0]          q
);

    logic [i8car_pkg::WORK_W-1:0] half;
    logic [i8car_pkg::WORK_W-1:0] sum_reg;

    assign half = (shamt == '0) ? '0 :
                  ({{(i8car_pkg::WORK_W-1){1'b0}}, 1'b1} << (shamt - 6'd1));

    always_ff @(posedge aclk) begin
        if (add_en) begin
            sum_reg <= value + half;
        end
    end

    assign q = $signed(sum_reg) >>> shamt;

endmodule

FILE: rtl/int8_conv_accumulate_requantize_top.sv
// ----------------------------------------------------------------------------
// int8_conv_accumulate_requantize_top
// Int8 multiply-accumulate with PReLU and requantization to int8.
// ----------------------------------------------------------------------------
// Each item is one product term. A term that is not the last passes through
// the accept state, which feeds the shared 32 x 32 multiplier, and the
// accumulate state. The last term passes ST_WORK, the two multiply halves,
// their sum, the rounding add and shift (twice, first with the slope, when
// PReLU applies to a negative value) and ST_FIN, which waits for the result
// register to drain. The single shared multiplier forms each 64 x 32 product
// in two halves. The input is not ready while a term is in flight; a finished
// result waits in its own output register while the next item is taken.
// ----------------------------------------------------------------------------
module int8_conv_accumulate_requantize_top #(
    parameter int unsigned BIAS_SHIFT = i8car_pkg::BIAS_SHIFT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // activation[7:0], weight[15:8], bias[79:16], mult[111:80], shift[117:112],
    // slope_mult[149:118], slope_shift[155:150], zero[159:156]
    input  logic [i8car_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // is_padding[0]
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tlast,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // result[7:0]
    output logic [i8car_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   cfg_we,
    input  logic [i8car_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [i8car_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int unsigned WW = i8car_pkg::WORK_W;
    localparam int unsigned CW = i8car_pkg::COEF_W;
    localparam int unsigned AW = i8car_pkg::ACT_W;

    i8car_pkg::state_t state_reg;
    i8car_pkg::state_t state_next;

    logic                                  prelu_en_reg;
    logic [AW-1:0]                         in_zp_reg;
    logic [AW-1:0]                         out_zp_reg;

    logic [i8car_pkg::ACC_W-1:0]           acc_reg;
    logic                                  last_reg;
    logic [WW-1:0]                         bias_reg;
    logic [CW-1:0]                         mult_reg;
    logic [i8car_pkg::SHAMT_W-1:0]         shift_reg;
    logic [CW-1:0]                         pmult_reg;
    logic [i8car_pkg::SHAMT_W-1:0]         pshift_reg;
    logic [WW-1:0]                         work_reg;
    logic [WW-1:0]                         plo_reg;
    logic                                  phase_reg;
    logic [i8car_pkg::OUT_DATA_W-1:0]      m_data_reg;
    logic                                  m_valid_reg;

    logic                                  accept;
    logic [AW-1:0]                         act_in;
    logic [AW-1:0]                         wgt_in;
    logic [CW-1:0]                         mul_a;
    logic [CW-1:0]                         mul_b;
    logic [WW-1:0]                         mul_p;
    logic [CW-1:0]                         coef;
    logic [CW-1:0]                         hi_part;
    logic [WW-1:0]                         work_calc;
    logic [i8car_pkg::TOTAL_W-1:0]         total_raw;
    logic [i8car_pkg::SHAMT_W-1:0]         total;
    logic [i8car_pkg::SHAMT_W-1:0]         shamt;
    logic                                  rnd_add;
    logic [WW-1:0]                         rnd_q;
    logic [WW-1:0]                         fin_sum;
    logic [i8car_pkg::OUT_DATA_W-1:0]      fin_sat;
    logic                                  out_free;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == i8car_pkg::ST_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign act_in = s_axis_tuser ? AW'(8'd0 - in_zp_reg) : s_axis_tdata[7:0];
    assign wgt_in = s_axis_tdata[15:8];

    assign coef    = phase_reg ? mult_reg : pmult_reg;
    assign hi_part = mul_p[CW-1:0] - (coef[CW-1] ? work_reg[CW-1:0] : '0);

    assign work_calc = ({{(WW-i8car_pkg::ACC_W){acc_reg[i8car_pkg::ACC_W-1]}}, acc_reg}
                        << BIAS_SHIFT) + bias_reg;

    assign total_raw = {1'b0, shift_reg} + i8car_pkg::TOTAL_W'(BIAS_SHIFT);
    assign total     = (total_raw > i8car_pkg::TOTAL_W'(i8car_pkg::SHAMT_MAX)) ?
                       i8car_pkg::SHAMT_MAX : total_raw[i8car_pkg::SHAMT_W-1:0];
    assign shamt     = phase_reg ? total : pshift_reg;
    assign rnd_add   = (state_reg == i8car_pkg::ST_RND_ADD);

    assign fin_sum = work_reg + {{(WW-AW){out_zp_reg[AW-1]}}, out_zp_reg};
    always_comb begin
        if ($signed(fin_sum) > $signed(64'sd127)) begin
            fin_sat = i8car_pkg::SAT_HI;
        end else if ($signed(fin_sum) < $signed(-64'sd128)) begin
            fin_sat = i8car_pkg::SAT_LO;
        end else begin
            fin_sat = fin_sum[i8car_pkg::OUT_DATA_W-1:0];
        end
    end

    always_comb begin
        case (state_reg)
            i8car_pkg::ST_MUL_LO: begin
                mul_a = work_reg[CW-1:0];
                mul_b = coef;
            end
            i8car_pkg::ST_MUL_HI: begin
                mul_a = work_reg[WW-1:CW];
                mul_b = coef;
            end
            default: begin
                mul_a = {{(CW-AW){act_in[AW-1]}}, act_in};
                mul_b = {{(CW-AW){wgt_in[AW-1]}}, wgt_in};
            end
        endcase
    end

    i8car_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    i8car_rnd u_rnd (
        .aclk   (aclk),
        .add_en (rnd_add),
        .value  (work_reg),
        .shamt  (shamt),
        .q      (rnd_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i8car_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            i8car_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = i8car_pkg::ST_MAC;
                end
            end
            i8car_pkg::ST_MAC: begin
                state_next = last_reg ? i8car_pkg::ST_WORK : i8car_pkg::ST_IDLE;
            end
            i8car_pkg::ST_WORK:      state_next = i8car_pkg::ST_MUL_LO;
            i8car_pkg::ST_MUL_LO:    state_next = i8car_pkg::ST_MUL_HI;
            i8car_pkg::ST_MUL_HI:    state_next = i8car_pkg::ST_MUL_SUM;
            i8car_pkg::ST_MUL_SUM:   state_next = i8car_pkg::ST_RND_ADD;
            i8car_pkg::ST_RND_ADD:   state_next = i8car_pkg::ST_RND_SHIFT;
            i8car_pkg::ST_RND_SHIFT: begin
                state_next = phase_reg ? i8car_pkg::ST_FIN : i8car_pkg::ST_MUL_LO;
            end
            i8car_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = i8car_pkg::ST_IDLE;
                end
            end
            default:                 state_next = i8car_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prelu_en_reg <= 1'b0;
            in_zp_reg    <= '0;
            out_zp_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                i8car_pkg::CFG_PRELU_ENABLE: prelu_en_reg <= cfg_wdata[0];
                i8car_pkg::CFG_IN_ZP:        in_zp_reg    <= cfg_wdata;
                i8car_pkg::CFG_OUT_ZP_ADD:   out_zp_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            phase_reg <= 1'b0;
        end else begin
            case (state_reg)
                i8car_pkg::ST_MAC: begin
                    acc_reg <= acc_reg + mul_p[i8car_pkg::ACC_W-1:0];
                end
                i8car_pkg::ST_WORK: begin
                    acc_reg   <= '0;
                    phase_reg <= !(prelu_en_reg && work_calc[WW-1]);
                end
                i8car_pkg::ST_RND_SHIFT: begin
                    phase_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg   <= s_axis_tlast;
            bias_reg   <= s_axis_tdata[79:16];
            mult_reg   <= s_axis_tdata[111:80];
            shift_reg  <= s_axis_tdata[117:112];
            pmult_reg  <= s_axis_tdata[149:118];
            pshift_reg <= s_axis_tdata[155:150];
        end
        case (state_reg)
            i8car_pkg::ST_WORK:      work_reg <= work_calc;
            i8car_pkg::ST_MUL_HI:    plo_reg  <= mul_p;
            i8car_pkg::ST_MUL_SUM:   work_reg <= plo_reg + {hi_part, {CW{1'b0}}};
            i8car_pkg::ST_RND_SHIFT: work_reg <= rnd_q;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == i8car_pkg::ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == i8car_pkg::ST_FIN && out_free) begin
            m_data_reg <= fin_sat;
        end
    end

    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tvalid = m_valid_reg;

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == i8car_pkg::ST_WORK) |=> (acc_reg == '0))
        else $error("accumulator not cleared after last term");

    a_fin_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == i8car_pkg::ST_FIN) |-> phase_reg)
        else $error("result formed before requantization pass");

    a_term_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == i8car_pkg::ST_MAC && !last_reg) |=> s_axis_tready)
        else $error("non-last term did not return to idle");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the int8 accumulate and requantize block.
// Streams product terms into the block and predicts each int8 result with a
// behavioural model of the accumulator, PReLU and requantization path. Covers
// directed extremes, padding, PReLU, shift saturation and several register
// settings, then random runs of terms with random idling on both sides and a
// long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [i8car_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned LIMIT_TIME    = 1000000;

    typedef struct {
        logic signed [7:0]  act;
        logic signed [7:0]  wgt;
        logic               pad;
        logic               last;
        logic signed [63:0] bias;
        logic signed [31:0] mult;
        logic [5:0]         shift;
        logic signed [31:0] pmult;
        logic [5:0]         pshift;
    } term_t;

    logic                                 aclk          = 1'b0;
    logic                                 aresetn       = 1'b0;
    // activation, weight, bias, mult, shift, slope_mult, slope_shift, zero pad
    logic [i8car_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    // is_padding
    logic                                 s_axis_tuser  = 1'b0;
    logic                                 s_axis_tlast  = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    // result
    logic [i8car_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic                                 cfg_we        = 1'b0;
    logic [i8car_pkg::CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [i8car_pkg::CFG_DATA_W-1:0]     cfg_wdata     = '0;

    logic                  prelu_on   = 1'b0;
    logic signed [7:0]     in_zp      = '0;
    logic signed [7:0]     out_zp_add = '0;
    logic [31:0]           acc_sum    = '0;

    logic [7:0] expected_results[$];
    logic [7:0] want;

    int  n_terms      = 0;
    int  n_results    = 0;
    int  n_errors     = 0;
    int  n_settings   = 1;
    int  tx_idle_pct  = 0;
    int  rx_idle_pct  = 0;
    int  rx_wait      = 0;
    bit  hold_request = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    int8_conv_accumulate_requantize_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    function automatic logic [63:0] round_shift(input logic [63:0] v, input int unsigned s);
        logic signed [63:0] t;
        if (s == 0)
            return v;
        t = v + (64'd1 << (s - 1));
        return t >>> s;
    endfunction

    function automatic bit predict_requant(input term_t t, output logic [7:0] q);
        logic signed [7:0]  a;
        logic signed [15:0] prod;
        logic [63:0]        work;
        logic signed [63:0] sw;
        int unsigned        total;
        a = t.pad ? -in_zp : t.act;
        prod = a * t.wgt;
        acc_sum = acc_sum + {{16{prod[15]}}, prod};
        q = '0;
        if (!t.last)
            return 1'b0;
        work = ({{32{acc_sum[31]}}, acc_sum} << i8car_pkg::BIAS_SHIFT_DEF) + t.bias;
        if (prelu_on && work[63])
            work = round_shift(work * {{32{t.pmult[31]}}, t.pmult}, t.pshift);
        total = t.shift + i8car_pkg::BIAS_SHIFT_DEF;
        if (total > 63)
            total = 63;
        work = round_shift(work * {{32{t.mult[31]}}, t.mult}, total)
             + {{56{out_zp_add[7]}}, out_zp_add};
        sw = work;
        if (sw > 127)
            q = i8car_pkg::SAT_HI;
        else if (sw < -128)
            q = i8car_pkg::SAT_LO;
        else
            q = sw[7:0];
        acc_sum = '0;
        return 1'b1;
    endfunction

    function automatic term_t mk_term(input logic signed [7:0] a, input logic signed [7:0] w,
                                      input logic pad, input logic last,
                                      input logic signed [63:0] bias,
                                      input logic signed [31:0] mult, input logic [5:0] shift,
                                      input logic signed [31:0] pm, input logic [5:0] ps);
        term_t t;
        t.act = a;     t.wgt = w;       t.pad = pad;   t.last = last;
        t.bias = bias; t.mult = mult;   t.shift = shift;
        t.pmult = pm;  t.pshift = ps;
        return t;
    endfunction

    function automatic logic signed [31:0] rand_coef();
        logic signed [31:0] c;
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        c = $urandom_range(32'h1000_0000, 32'h7fff_ffff);
        if ($urandom_range(0, 1) == 1)
            c = -c;
        return c;
    endfunction

    function automatic term_t rand_term(input bit last);
        term_t t;
        int    v;
        t.act  = 8'($urandom);
        t.wgt  = 8'($urandom);
        t.pad  = ($urandom_range(0, 99) < 15);
        t.last = last;
        if ($urandom_range(0, 2) == 0) begin
            t.bias = {$urandom, $urandom};
        end else begin
            v = $urandom_range(0, 32'h07ff_ffff);
            t.bias = v - 67108864;
        end
        t.mult   = rand_coef();
        t.pmult  = rand_coef();
        t.shift  = ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'($urandom_range(30, 45));
        t.pshift = ($urandom_range(0, 2) == 0) ? 6'($urandom) : 6'($urandom_range(24, 34));
        return t;
    endfunction

    task automatic send_term(input term_t t);
        logic [7:0] q;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, t.pshift, t.pmult, t.shift, t.mult, t.bias, t.wgt, t.act};
        s_axis_tuser  <= t.pad;
        s_axis_tlast  <= t.last;
        do @(posedge aclk); while (!s_axis_tready);
        if (predict_requant(t, q))
            expected_results.push_back(q);
        n_terms++;
    endtask

    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(input logic pe, input logic signed [7:0] izp,
                                input logic signed [7:0] ozp);
        cfg_we    <= 1'b1;
        cfg_index <= i8car_pkg::CFG_PRELU_ENABLE;
        cfg_wdata <= {7'b0, pe};
        @(posedge aclk);
        cfg_index <= i8car_pkg::CFG_IN_ZP;
        cfg_wdata <= izp;
        @(posedge aclk);
        cfg_index <= i8car_pkg::CFG_OUT_ZP_ADD;
        cfg_wdata <= ozp;
        @(posedge aclk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= 8'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
        prelu_on   = pe;
        in_zp      = izp;
        out_zp_add = ozp;
        n_settings++;
    endtask

    task automatic test_reset_values();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_term(mk_term(127, 127, 0, 1, 0, 32'sh7fff_ffff, 0, 0, 0));
        send_term(mk_term(-128, -128, 0, 0, 0, 0, 0, 0, 0));
        send_term(mk_term(-128, 127, 0, 1, -1, 1, 0, 0, 0));
        send_term(mk_term(5, 9, 1, 1, 64'sh7fff_ffff_ffff_ffff, 32'sh8000_0000, 63, 0, 0));
        send_term(mk_term(-100, 3, 0, 1, 0, 32'sh4000_0000, 30, 32'sh4000_0000, 30));
        send_term(mk_term(0, 0, 0, 1, 64'sh8000_0000_0000_0000, 1, 0, 0, 0));
        send_term(mk_term(1, 1, 0, 1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_prelu_and_padding();
        drain_block();
        apply_config(1'b1, -128, 127);
        send_term(mk_term(3, -128, 1, 1, 0, 32'sh4000_0000, 30, 32'sh4000_0000, 30));
        send_term(mk_term(-7, 100, 0, 1, 0, 32'sh4000_0000, 24, 32'sh7fff_ffff, 0));
        send_term(mk_term(-7, 100, 0, 1, 0, 32'sh4000_0000, 30, 32'sh8000_0000, 63));
        send_term(mk_term(0, 0, 0, 1, -1, 32'sh4000_0000, 20, 32'sh0010_0000, 20));
        send_term(mk_term(0, 0, 0, 1, 0, 32'sh4000_0000, 20, 32'sh0010_0000, 20));
        drain_block();
        apply_config(1'b1, 127, -128);
        send_term(mk_term(-128, -128, 1, 0, 0, 0, 0, 0, 0));
        send_term(mk_term(127, -128, 0, 1, 0, 32'sh4000_0000, 55, 32'sh7fff_ffff, 31));
        send_term(mk_term(50, -50, 0, 1, 0, 32'sh7fff_ffff, 56, 32'sh4000_0000, 31));
        send_term(mk_term(-128, 127, 1, 1, 64'sh7fff_ffff_ffff_ffff, 1, 63, 1, 63));
        send_term(mk_term(10, 10, 0, 1, 0, 32'sh4000_0000, 33, 32'sh4000_0000, 30));
    endtask

    task automatic test_output_backpressure();
        int k;
        drain_block();
        apply_config(1'b0, 8'($urandom), 8'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 1'b1;
        for (k = 0; k < 30; k++)
            send_term(rand_term($urandom_range(0, 1) == 1));
    endtask

    task automatic test_random_traffic(input logic pe, input logic signed [7:0] izp,
                                       input logic signed [7:0] ozp, input int n_items,
                                       input int tx_pct, input int rx_pct);
        int sent;
        int run_len;
        int k;
        drain_block();
        apply_config(pe, izp, ozp);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
            for (k = 0; k < run_len; k++)
                send_term(rand_term(k == run_len - 1));
            sent += run_len;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (hold_request) begin
                rx_wait = HOLD_CYCLES;
                hold_request = 1'b0;
            end else if (rx_wait == 0 && rx_idle_pct != 0
                         && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_wait = $urandom_range(1, 17);
            end
            if (rx_wait != 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, $signed(m_axis_tdata));
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== want) begin
                    $display("%0t: result mismatch, expected %0d, actual %0d",
                             $time, $signed(want), $signed(m_axis_tdata));
                    n_errors++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_prelu_and_padding();
        test_output_backpressure();
        test_random_traffic(1'b0, 0, 0, 95, 30, 30);
        test_random_traffic(1'b1, -128, -128, 95, 10, 50);
        test_random_traffic(1'b1, 127, 127, 95, 50, 10);
        test_random_traffic(1'b0, 127, -128, 95, 0, 20);
        test_random_traffic(1'b1, 8'($urandom), 8'($urandom), 95, 20, 0);
        test_random_traffic(1'b1, 8'($urandom), 8'($urandom), 95, 0, 0);
        drain_block();
        $display("Sent %0d terms, checked %0d results over %0d register settings,",
                 n_terms, n_results, n_settings);
        $display("including padding, PReLU, shift limits, saturation and a long hold-off.");
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
